/* rtl/core/tmtg_pkg.sv */
// tmtg_pkg: widths, register indexes, the result record and clamp helpers
// for the tile mean threshold grid. Standalone; imported by every module of the block.
`default_nettype none

package tmtg_pkg;

  localparam int NUM_CELLS  = 64;
  localparam int CELL_W     = 6;   // cell coordinate / sum memory address
  localparam int POS_W      = 12;  // scan position along either index
  localparam int REM_W      = 6;   // position within a tile
  localparam int TILE_W     = 7;   // tile size and cell count registers
  localparam int LINE_W     = 13;  // line length and line count registers
  localparam int MAXV_W     = 8;
  localparam int SUM_W      = 20;
  localparam int AREA_W     = 13;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS  = POS_W;
  localparam int DIV_CNT_W  = 4;

  localparam logic [TILE_W-1:0] MAX_TILE  = 7'd64;
  localparam logic [TILE_W-1:0] MAX_CELLS = 7'd64;
  localparam logic [LINE_W-1:0] MAX_LINE  = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_OUTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_INNER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_OUTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_INNER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE   = 3'd6;

  typedef struct packed {
    logic              last_cell;
    logic              filled;
    logic [CELL_W-1:0] cell_inner;
    logic [CELL_W-1:0] cell_outer;
  } result_t;

  function automatic logic [TILE_W-1:0] clamp_small(input logic [TILE_W-1:0] v,
                                                    input logic [TILE_W-1:0] hi);
    logic [TILE_W-1:0] r;
    r = v;
    if (v == '0) r = TILE_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [LINE_W-1:0] clamp_line(input logic [LINE_W-1:0] v);
    logic [LINE_W-1:0] r;
    r = v;
    if (v == '0) r = LINE_W'(1);
    else if (v > MAX_LINE) r = MAX_LINE;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tile_mean_threshold_grid.sv */
// tile_mean_threshold_grid: block-average downsampler with binarization.
// Depends on tmtg_pkg and tmtg_div.
//
//   channel | dir | payload                                        | handshake
//   s_      | in  | tdata[7:0] pixel                               | tvalid/tready
//   m_      | out | tdata[5:0] cell_outer, [11:6] cell_inner,      | tvalid/tready
//           |     | [12] filled; tlast last_cell                   |
//   cfg_    | in  | cfg_index selects register, cfg_wdata value    | cfg_we, no wait
//
// One pixel per cycle: a request reads its column sum from the sum memory, the next
// cycle adds the pixel and writes it back, with forwarding on back-to-back hits.
// After reset and after every configuration write the tile position is rebuilt by
// a bit-serial divider, then two multiply steps (area, threshold); ready stays low throughout.
// Input ready also drops while two results are queued or on their way to the output.
// Column sums live in a 64 x 20 memory; per-entry valid bits make reset and image
// wrap clear it at once.
`default_nettype none

module tile_mean_threshold_grid (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [7:0] pixel
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [15:0]                          m_tdata,   // [5:0] cell_outer, [11:6] cell_inner,
                                                          // [12] filled, [15:13] zero
  output logic                                 m_tlast,
  input  wire logic                            cfg_we,
  input  wire logic [tmtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmtg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tmtg_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_AREA = 2'd2;
  localparam logic [1:0] ST_THR  = 2'd3;
  localparam logic [2:0] ST_RUN_FLAG = 3'd4;

  // configuration registers
  logic [TILE_W-1:0] tile_outer, tile_inner, cells_outer, cells_inner;
  logic [LINE_W-1:0] line_length, line_count;
  logic [MAXV_W-1:0] max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_outer  <= TILE_W'(1);
      tile_inner  <= TILE_W'(1);
      cells_outer <= TILE_W'(1);
      cells_inner <= TILE_W'(1);
      line_length <= LINE_W'(1);
      line_count  <= LINE_W'(1);
      max_value   <= MAXV_W'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_OUTER:  tile_outer  <= cfg_wdata[TILE_W-1:0];
        REG_TILE_INNER:  tile_inner  <= cfg_wdata[TILE_W-1:0];
        REG_CELLS_OUTER: cells_outer <= cfg_wdata[TILE_W-1:0];
        REG_CELLS_INNER: cells_inner <= cfg_wdata[TILE_W-1:0];
        REG_LINE_LENGTH: line_length <= cfg_wdata;
        REG_LINE_COUNT:  line_count  <= cfg_wdata;
        REG_MAX_VALUE:   max_value   <= cfg_wdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  logic [TILE_W-1:0] to_c, ti_c, co_c, ci_c;
  logic [LINE_W-1:0] len_c, cnt_c;
  logic [MAXV_W-1:0] thr_mult;

  assign to_c     = clamp_small(tile_outer, MAX_TILE);
  assign ti_c     = clamp_small(tile_inner, MAX_TILE);
  assign co_c     = clamp_small(cells_outer, MAX_CELLS);
  assign ci_c     = clamp_small(cells_inner, MAX_CELLS);
  assign len_c    = clamp_line(line_length);
  assign cnt_c    = clamp_line(line_count);
  // mean > half  <=>  sum >= (half + 1) * area
  assign thr_mult = {1'b0, max_value[MAXV_W-1:1]} + MAXV_W'(1);

  // recompute sequencer
  logic [2:0] state;   // bit 2 marks run, low bits the recompute step
  logic       running;
  logic       div_start, div_done, div_done_i;
  logic [POS_W-1:0] q_o, q_i;
  logic [REM_W-1:0] r_o, r_i;
  logic [AREA_W-1:0] area;
  logic [SUM_W-1:0]  thresh;
  logic [2*TILE_W-1:0] area_full;
  logic [AREA_W+MAXV_W-1:0] thr_full;

  assign running   = state[2];
  assign div_start = (state == {1'b0, ST_LOAD});
  assign area_full = to_c * ti_c;
  assign thr_full  = area * thr_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= {1'b0, ST_LOAD};
    end else if (cfg_we) begin
      state <= {1'b0, ST_LOAD};
    end else begin
      case (state)
        {1'b0, ST_LOAD}: state <= {1'b0, ST_DIV};
        {1'b0, ST_DIV}:  if (div_done) state <= {1'b0, ST_AREA};
        {1'b0, ST_AREA}: state <= {1'b0, ST_THR};
        {1'b0, ST_THR}:  state <= ST_RUN_FLAG;
        ST_RUN_FLAG:     state <= ST_RUN_FLAG;
        default:         state <= {1'b0, ST_LOAD};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == {1'b0, ST_AREA}) area <= area_full[AREA_W-1:0];
    if (state == {1'b0, ST_THR})  thresh <= thr_full[SUM_W-1:0];
  end

  // scan position, tile offset and cell index along both axes
  logic [POS_W-1:0] pos_o, pos_i, cell_o, cell_i;
  logic [REM_W-1:0] rem_o, rem_i;

  tmtg_div u_div_outer (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pos_o),
    .divisor   (to_c),
    .done      (div_done),
    .quotient  (q_o),
    .remainder (r_o)
  );

  tmtg_div u_div_inner (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pos_i),
    .divisor   (ti_c),
    .done      (div_done_i),
    .quotient  (q_i),
    .remainder (r_i)
  );

  // output queue, two entries
  result_t           q_mem [2];
  logic              q_wp, q_rp;
  logic [1:0]        q_cnt;
  logic              q_push, q_pop;

  // stage 1 registers
  logic              s1_valid, s1_emit, s1_wrap, s1_last;
  logic [CELL_W-1:0] s1_addr, s1_co;
  logic [PIX_W-1:0]  s1_pix;

  logic [1:0] pending;
  logic       acc;

  assign pending  = q_cnt + {1'b0, s1_valid & s1_emit};
  assign s_tready = running && (pending < 2'd2);
  assign acc      = s_tvalid && s_tready;

  // per-pixel decode
  logic in_grid, tile_end, last_now;
  logic [LINE_W-1:0] i_inc, o_inc;
  logic line_end, img_end;
  logic [TILE_W-1:0] rem_i_inc, rem_o_inc;

  assign in_grid   = (cell_o < POS_W'(co_c)) && (cell_i < POS_W'(ci_c));
  assign tile_end  = ({1'b0, rem_o} == to_c - TILE_W'(1)) &&
                     ({1'b0, rem_i} == ti_c - TILE_W'(1));
  assign last_now  = (cell_o == POS_W'(co_c - TILE_W'(1))) &&
                     (cell_i == POS_W'(ci_c - TILE_W'(1)));
  assign i_inc     = {1'b0, pos_i} + LINE_W'(1);
  assign o_inc     = {1'b0, pos_o} + LINE_W'(1);
  assign line_end  = i_inc >= len_c;
  assign img_end   = line_end && (o_inc >= cnt_c);
  assign rem_i_inc = {1'b0, rem_i} + TILE_W'(1);
  assign rem_o_inc = {1'b0, rem_o} + TILE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_o  <= '0;
      pos_i  <= '0;
      cell_o <= '0;
      cell_i <= '0;
      rem_o  <= '0;
      rem_i  <= '0;
    end else if ((state == {1'b0, ST_DIV}) && div_done) begin
      cell_o <= q_o;
      rem_o  <= r_o;
      cell_i <= q_i;
      rem_i  <= r_i;
    end else if (acc) begin
      if (line_end) begin
        pos_i  <= '0;
        rem_i  <= '0;
        cell_i <= '0;
        if (img_end) begin
          pos_o  <= '0;
          rem_o  <= '0;
          cell_o <= '0;
        end else begin
          pos_o <= o_inc[POS_W-1:0];
          if (rem_o_inc == to_c) begin
            rem_o  <= '0;
            cell_o <= cell_o + POS_W'(1);
          end else begin
            rem_o <= rem_o_inc[REM_W-1:0];
          end
        end
      end else begin
        pos_i <= i_inc[POS_W-1:0];
        if (rem_i_inc == ti_c) begin
          rem_i  <= '0;
          cell_i <= cell_i + POS_W'(1);
        end else begin
          rem_i <= rem_i_inc[REM_W-1:0];
        end
      end
    end
  end

  // column sum memory with valid bits
  logic [SUM_W-1:0]     sum_mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] sum_ok;
  logic [SUM_W-1:0]     rd_data;
  logic                 rd_ok;
  logic                 wr_en;
  logic [SUM_W-1:0]     wr_data;
  logic                 fwd_valid;
  logic [CELL_W-1:0]    fwd_addr;
  logic [SUM_W-1:0]     fwd_data;
  logic [SUM_W-1:0]     sum_old, sum_new;

  assign sum_old = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data :
                   (rd_ok ? rd_data : '0);
  assign sum_new = sum_old + SUM_W'(s1_pix);
  // the pixel that closes an image writes no sum back, since the wrap clears them anyway
  assign wr_en   = s1_valid && !s1_wrap;
  assign wr_data = s1_emit ? '0 : sum_new;

  always_ff @(posedge clk) begin
    if (wr_en) sum_mem[s1_addr] <= wr_data;
    if (acc) begin
      rd_data <= sum_mem[cell_i[CELL_W-1:0]];
      rd_ok   <= sum_ok[cell_i[CELL_W-1:0]];
    end
    fwd_addr <= s1_addr;
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ok    <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      if (acc && img_end) sum_ok <= '0;
      else if (wr_en) sum_ok[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= acc && in_grid;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr <= cell_i[CELL_W-1:0];
      s1_co   <= cell_o[CELL_W-1:0];
      s1_pix  <= s_tdata;
      s1_emit <= tile_end;
      s1_wrap <= img_end;
      s1_last <= last_now;
    end
  end

  // result queue
  result_t res;
  assign res.cell_outer = s1_co;
  assign res.cell_inner = s1_addr;
  assign res.filled     = sum_new >= thresh;
  assign res.last_cell  = s1_last;

  assign q_push = s1_valid && s1_emit;
  assign q_pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (q_push) q_mem[q_wp] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= 1'b0;
      q_rp  <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (q_push) q_wp <= ~q_wp;
      if (q_pop)  q_rp <= ~q_rp;
      q_cnt <= q_cnt + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  result_t head;
  assign head     = q_mem[q_rp];
  assign m_tvalid = (q_cnt != '0);
  assign m_tdata  = {3'b000, head.filled, head.cell_inner, head.cell_outer};
  assign m_tlast  = head.last_cell;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 2'd2)
    else $error("result queue over capacity");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |-> (q_cnt < 2'd2))
    else $error("result pushed into full queue");

  a_offset_in_tile: assert property (@(posedge clk) disable iff (rst)
    running |-> (({1'b0, rem_i} < ti_c) && ({1'b0, rem_o} < to_c)))
    else $error("tile offset out of range");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && img_end) |=> (sum_ok == '0))
    else $error("column sums survive image wrap");

  a_no_accept_recompute: assert property (@(posedge clk) disable iff (rst)
    !running |-> !s_tready)
    else $error("pixel taken during geometry recompute");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_done == div_done_i)
    else $error("dividers out of step");
`endif

endmodule

`default_nettype wire

/* rtl/core/tmtg_div.sv */
// tmtg_div: restoring divider, one quotient bit per cycle, splits a scan
// position into tile index and offset within the tile. Uses tmtg_pkg.
`default_nettype none

module tmtg_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tmtg_pkg::POS_W-1:0]  dividend,
  input  wire logic [tmtg_pkg::TILE_W-1:0] divisor,
  output logic                             done,
  output logic [tmtg_pkg::POS_W-1:0]       quotient,
  output logic [tmtg_pkg::REM_W-1:0]       remainder
);
  import tmtg_pkg::*;

  logic [DIV_CNT_W-1:0] steps;
  logic [TILE_W-1:0]    trial;
  logic                 fits;

  // remainder stays below the divisor (at most 64), so one shifted-in bit fits in 7 bits
  assign trial = {remainder, quotient[POS_W-1]};
  assign fits  = trial >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= DIV_CNT_W'(DIV_STEPS);
      done  <= 1'b0;
    end else begin
      done <= (steps == DIV_CNT_W'(1));
      if (steps != '0) steps <= steps - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (steps != '0) begin
      if (fits) begin
        remainder <= REM_W'(trial - divisor);
        quotient  <= {quotient[POS_W-2:0], 1'b1};
      end else begin
        remainder <= trial[REM_W-1:0];
        quotient  <= {quotient[POS_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tile_mean_threshold_grid_test.sv */
// Self-checking test of tile_mean_threshold_grid: pixel requests in scan order,
// cell results compared field by field against an in-bench tile sum predictor.
// Depends on tmtg_pkg and the block's RTL only.
`default_nettype none

module tile_mean_threshold_grid_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtg_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles with no request moving on either side
  localparam int SETTLE      = 20;     // pipeline flush before a register write
  localparam int NUM_REGS    = 7;
  localparam int unsigned REG_MASK [NUM_REGS] = '{
    32'h7F, 32'h7F, 32'h7F, 32'h7F, 32'h1FFF, 32'h1FFF, 32'hFF
  };

  typedef enum {PIX_UNIFORM, PIX_NEAR_HALF, PIX_EXTREME, PIX_BRIGHT} pixel_mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;     // [7:0] pixel
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;          // [5:0] cell_outer, [11:6] cell_inner, [12] filled
  logic                  m_tlast;          // last_cell
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tile_mean_threshold_grid dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int unsigned reg_val [NUM_REGS] = '{1, 1, 1, 1, 1, 1, 255};
  int unsigned column_sum [NUM_CELLS];
  int unsigned scan_outer = 0;
  int unsigned scan_inner = 0;
  result_t     expected_cells [$];
  int unsigned cells_predicted = 0;

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          ready_hold_left = 0;
  logic [15:0] ready_pattern = '1;
  logic [3:0]  pattern_pos = '0;
  result_t     oldest_cell;

  initial begin
    foreach (column_sum[k]) column_sum[k] = 0;
  end

  function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_pixel(input logic [7:0] pix);
    int unsigned to, ti, co, ci, len, cnt, half, cell_o, cell_i, sum;
    result_t r;
    to = bounded(reg_val[REG_TILE_OUTER], 64);
    ti = bounded(reg_val[REG_TILE_INNER], 64);
    co = bounded(reg_val[REG_CELLS_OUTER], 64);
    ci = bounded(reg_val[REG_CELLS_INNER], 64);
    len = bounded(reg_val[REG_LINE_LENGTH], 4096);
    cnt = bounded(reg_val[REG_LINE_COUNT], 4096);
    half = reg_val[REG_MAX_VALUE] >> 1;
    cell_o = scan_outer / to;
    cell_i = scan_inner / ti;
    if (cell_o < co && cell_i < ci) begin
      sum = column_sum[cell_i] + pix;
      if (scan_outer % to == to - 1 && scan_inner % ti == ti - 1) begin
        r.cell_outer = cell_o[CELL_W-1:0];
        r.cell_inner = cell_i[CELL_W-1:0];
        r.filled = (sum / (to * ti)) > half;
        r.last_cell = (cell_o == co - 1) && (cell_i == ci - 1);
        expected_cells.push_back(r);
        cells_predicted++;
        column_sum[cell_i] = 0;
      end else begin
        column_sum[cell_i] = sum;
      end
    end
    scan_inner++;
    if (scan_inner >= len) begin
      scan_inner = 0;
      scan_outer++;
      if (scan_outer >= cnt) begin
        scan_outer = 0;
        foreach (column_sum[k]) column_sum[k] = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // one pixel request; valid stays high afterwards so a burst runs back to back
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    predict_pixel(pix);
    @(negedge clk);
  endtask

  task automatic stop_pixels();
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apply_geometry(input int unsigned to, input int unsigned ti,
                                input int unsigned co, input int unsigned ci,
                                input int unsigned len, input int unsigned cnt,
                                input int unsigned maxv);
    int unsigned setting [NUM_REGS];
    setting[REG_TILE_OUTER] = to;
    setting[REG_TILE_INNER] = ti;
    setting[REG_CELLS_OUTER] = co;
    setting[REG_CELLS_INNER] = ci;
    setting[REG_LINE_LENGTH] = len;
    setting[REG_LINE_COUNT] = cnt;
    setting[REG_MAX_VALUE] = maxv;
    wait_drained();
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_wdata <= CFG_DATA_W'(setting[k] & REG_MASK[k]);
      @(negedge clk);
      reg_val[k] = setting[k] & REG_MASK[k];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel(input pixel_mix_t mix);
    int v;
    case (mix)
      PIX_NEAR_HALF: begin
        v = int'(reg_val[REG_MAX_VALUE] >> 1) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
      PIX_BRIGHT:  v = 200 + $urandom_range(0, 55);
      default:     v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  // defaults after reset: every pixel is a whole 1x1 grid, threshold 127
  task automatic test_reset_values();
    send_pixel(8'd0);
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd255);
    stop_pixels();
  endtask

  task automatic test_threshold();
    apply_geometry(1, 2, 1, 1, 2, 1, 255);
    send_pixel(8'd128);   // mean floors to 127, not above half
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd128);
    stop_pixels();
    apply_geometry(1, 1, 1, 1, 1, 1, 0);   // zero threshold
    send_pixel(8'd0);
    send_pixel(8'd1);
    stop_pixels();
    apply_geometry(1, 1, 1, 1, 1, 1, 1);
    send_pixel(8'd1);
    send_pixel(8'd0);
    stop_pixels();
  endtask

  // three lines of a grid that wants eight: second tile never completes and wrap clears it
  task automatic test_image_wrap();
    apply_geometry(2, 1, 4, 1, 1, 3, 255);
    send_pixel(8'd200);
    send_pixel(8'd200);
    send_pixel(8'd200);
    send_pixel(8'd10);
    send_pixel(8'd10);
    stop_pixels();
  endtask

  task automatic test_out_of_range();
    apply_geometry(0, 0, 127, 127, 8191, 0, 255);
    repeat (5) send_pixel(pick_pixel(PIX_UNIFORM));
    stop_pixels();
    apply_geometry(127, 127, 0, 0, 0, 8191, 255);
    repeat (3) send_pixel(pick_pixel(PIX_UNIFORM));
    stop_pixels();
  endtask

  task automatic test_grid_extremes();
    apply_geometry(1, 1, 64, 64, 4096, 4096, 255);
    repeat (70) send_pixel(pick_pixel(PIX_UNIFORM));
    stop_pixels();
    apply_geometry(1, 1, 64, 1, 1, 64, 254);
    repeat (70) send_pixel(pick_pixel(PIX_UNIFORM));
    stop_pixels();
    // largest tile along each axis, full-scale pixels; two images guarantee one whole tile
    apply_geometry(64, 1, 1, 1, 1, 64, 255);
    repeat (128) send_pixel(8'd255);
    stop_pixels();
    apply_geometry(1, 64, 1, 1, 64, 1, 255);
    repeat (128) send_pixel(8'd255);
    stop_pixels();
  endtask

  task automatic test_backpressure();
    apply_geometry(1, 1, 8, 8, 8, 8, 255);
    gaps_on = 1'b0;
    ready_hold_left = 300;
    repeat (80) send_pixel(pick_pixel(PIX_UNIFORM));
    stop_pixels();
    wait_drained();
    gaps_on = 1'b1;
    repeat (40) send_pixel(pick_pixel(PIX_NEAR_HALF));
    stop_pixels();
  endtask

  task automatic test_random_scans();
    int unsigned sent, first_cell, to, ti, co, ci, n;
    pixel_mix_t mix;
    sent = 0;
    first_cell = cells_predicted;
    while (sent < 800 || cells_predicted - first_cell < 48) begin
      if ($urandom_range(0, 7) == 0) begin
        apply_geometry($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 255));
      end else begin
        to = $urandom_range(1, 4);
        ti = $urandom_range(1, 4);
        co = $urandom_range(1, 4);
        ci = $urandom_range(1, 6);
        apply_geometry(to, ti, co, ci, ci * ti + $urandom_range(0, 3),
                       co * to + $urandom_range(0, 2),
                       $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
      end
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      mix = pixel_mix_t'($urandom_range(0, 3));
      n = $urandom_range(40, 200);
      repeat (n) send_pixel(pick_pixel(mix));
      sent += n;
      stop_pixels();
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // result side: own stall pattern, plus a long hold-off on request from a test
  always @(negedge clk) begin
    if (ready_hold_left > 0) begin
      m_tready <= 1'b0;
      ready_hold_left--;
    end else if (!stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      if (pattern_pos == 0)
        ready_pattern = 16'($urandom_range(0, 1) ? ($urandom | $urandom) : $urandom);
      m_tready <= ready_pattern[pattern_pos];
      pattern_pos = pattern_pos + 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
      end else begin
        oldest_cell = expected_cells.pop_front();
        if (m_tdata[5:0] != oldest_cell.cell_outer)
          report_mismatch("cell_outer", int'(m_tdata[5:0]), int'(oldest_cell.cell_outer));
        if (m_tdata[11:6] != oldest_cell.cell_inner)
          report_mismatch("cell_inner", int'(m_tdata[11:6]), int'(oldest_cell.cell_inner));
        if (m_tdata[12] != oldest_cell.filled)
          report_mismatch("filled", int'(m_tdata[12]), int'(oldest_cell.filled));
        if (m_tlast != oldest_cell.last_cell)
          report_mismatch("last_cell", int'(m_tlast), int'(oldest_cell.last_cell));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tile_mean_threshold_grid_test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_threshold();
    test_image_wrap();
    test_out_of_range();
    test_grid_extremes();
    test_backpressure();
    test_random_scans();
    wait_drained();
    if (mismatches == 0) begin
      $display("tile_mean_threshold_grid_test passed");
    end else begin
      $display("tile_mean_threshold_grid_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
